>>> rtl/core/jqc_pkg.sv
// jqc_pkg: shared codes and types for the job queue with cancel by key
// used by jqc_cell and job_queue_with_cancel_by_id_unit; no dependencies
package jqc_pkg;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;
  localparam logic [1:0] ACT_FIND   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  localparam int CAP_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  // per-cell control from the queue sequencer
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

>>> rtl/core/job_queue_with_cancel_by_id_unit.sv
// job_queue_with_cancel_by_id_unit: bounded job queue with remove by key
// top level; a row of jqc_cell slots, occupancy count, result register
// depends on jqc_pkg and jqc_cell
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_action, in_job_key, in_job_handle
//  out     | output    | out_valid/out_stall| out_status, out_handle_out,
//          |           |                    | out_position, out_entry_count
//  cfg     | input     | apb, pready high   | capacity_limit at byte 0
//
// one word per cycle unless stalled: the key compare and the shift of the slot
// row finish in the cycle a word is accepted, and the result appears in the
// output register in the next cycle. a word is taken while the output register
// is empty or being drained. reset empties the queue and sets the capacity to
// 16; slot contents are not cleared. a stall on the result side holds the input
module job_queue_with_cancel_by_id_unit #(
  parameter int DEPTH       = 16,
  parameter int KEY_BITS    = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_action,
  input  logic [KEY_BITS-1:0]            in_job_key,
  input  logic [HANDLE_BITS-1:0]         in_job_handle,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic [HANDLE_BITS-1:0]         out_handle_out,
  output logic [$clog2(DEPTH+1)-1:0]     out_position,
  output logic [$clog2(DEPTH+1)-1:0]     out_entry_count,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [2:0]                     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LIM_W = (CNT_W > jqc_pkg::CAP_BITS) ? CNT_W : jqc_pkg::CAP_BITS;
  localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(DEPTH);

  logic [jqc_pkg::CAP_BITS-1:0] cap_r;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic                         out_valid_r;
  logic [1:0]                   status_r, status_nxt;
  logic [HANDLE_BITS-1:0]       hout_r, hout_nxt;
  logic [CNT_W-1:0]             pos_r, pos_nxt;

  jqc_pkg::cell_ctl_t     ctl      [DEPTH];
  logic [KEY_BITS-1:0]    key_q    [DEPTH];
  logic [HANDLE_BITS-1:0] handle_q [DEPTH];
  logic [KEY_BITS-1:0]    nb_key   [DEPTH];
  logic [HANDLE_BITS-1:0] nb_handle[DEPTH];
  logic [DEPTH-1:0]       occupied, hit, above, win, at_or_below;

  logic             accept, full, found;
  logic [LIM_W-1:0] cap_l, limit, count_l;
  logic [CNT_W-1:0] win_pos;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {{(32-jqc_pkg::CAP_BITS){1'b0}}, cap_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= jqc_pkg::CAP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
      cap_r <= cfg_pwdata[jqc_pkg::CAP_BITS-1:0];
    end
  end

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign cap_l   = LIM_W'(cap_r);
  assign count_l = LIM_W'(count_r);
  assign limit   = (cap_l < DEPTH_L) ? cap_l : DEPTH_L;
  assign full    = count_l >= limit;

  // slot row
  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g == DEPTH - 1) begin : g_last
        assign nb_key[g]    = key_q[g];
        assign nb_handle[g] = handle_q[g];
        assign above[g]     = 1'b0;
      end else begin : g_mid
        assign nb_key[g]    = key_q[g+1];
        assign nb_handle[g] = handle_q[g+1];
        assign above[g]     = above[g+1] | hit[g+1];
      end
      if (g == 0) begin : g_first
        assign at_or_below[g] = win[g];
      end else begin : g_rest
        assign at_or_below[g] = at_or_below[g-1] | win[g];
      end

      assign occupied[g] = count_r > CNT_W'(g);
      assign win[g]      = hit[g] & ~above[g];

      assign ctl[g].load  = accept && (in_action == jqc_pkg::ACT_INSERT) && !full &&
                            (count_r == CNT_W'(g));
      assign ctl[g].shift = accept &&
                            (((in_action == jqc_pkg::ACT_POP) && (count_r != '0)) ||
                             ((in_action == jqc_pkg::ACT_CANCEL) && at_or_below[g]));

      jqc_cell #(
        .KEY_BITS   (KEY_BITS),
        .HANDLE_BITS(HANDLE_BITS)
      ) u_cell (
        .clk      (clk),
        .ctl      (ctl[g]),
        .occupied (occupied[g]),
        .key_in   (in_job_key),
        .handle_in(in_job_handle),
        .nb_key   (nb_key[g]),
        .nb_handle(nb_handle[g]),
        .key_q    (key_q[g]),
        .handle_q (handle_q[g]),
        .hit      (hit[g])
      );
    end
  endgenerate

  assign found = above[0] | hit[0];

  always_comb begin
    win_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (win[i]) win_pos = win_pos | CNT_W'(i + 1);
    end
  end

  // result for the word at the input
  always_comb begin
    status_nxt = jqc_pkg::ST_OK;
    hout_nxt   = '0;
    pos_nxt    = '0;
    count_nxt  = count_r;
    unique case (in_action)
      jqc_pkg::ACT_INSERT: begin
        if (full) status_nxt = jqc_pkg::ST_FULL;
        else      count_nxt  = count_r + CNT_W'(1);
      end
      jqc_pkg::ACT_POP: begin
        if (count_r == '0) begin
          status_nxt = jqc_pkg::ST_EMPTY;
        end else begin
          hout_nxt  = handle_q[0];
          count_nxt = count_r - CNT_W'(1);
        end
      end
      jqc_pkg::ACT_CANCEL: begin
        if (!found) begin
          status_nxt = jqc_pkg::ST_MISSING;
        end else begin
          pos_nxt   = win_pos;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      jqc_pkg::ACT_FIND: begin
        if (!found) status_nxt = jqc_pkg::ST_MISSING;
        else        pos_nxt    = win_pos;
      end
      default: status_nxt = jqc_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      hout_r   <= hout_nxt;
      pos_r    <= pos_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_handle_out  = hout_r;
  assign out_position    = pos_r;
  assign out_entry_count = count_r;

endmodule

>>> rtl/core/jqc_cell.sv
// jqc_cell: one queue slot holding a key and a handle
// loads a new entry, takes its rear neighbor's entry, and compares its key
// depends on jqc_pkg
module jqc_cell #(
  parameter int KEY_BITS    = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic                   clk,
  input  jqc_pkg::cell_ctl_t     ctl,
  input  logic                   occupied,
  input  logic [KEY_BITS-1:0]    key_in,
  input  logic [HANDLE_BITS-1:0] handle_in,
  input  logic [KEY_BITS-1:0]    nb_key,
  input  logic [HANDLE_BITS-1:0] nb_handle,
  output logic [KEY_BITS-1:0]    key_q,
  output logic [HANDLE_BITS-1:0] handle_q,
  output logic                   hit
);

  logic [KEY_BITS-1:0]    key_r;
  logic [HANDLE_BITS-1:0] handle_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r    <= key_in;
      handle_r <= handle_in;
    end else if (ctl.shift) begin
      key_r    <= nb_key;
      handle_r <= nb_handle;
    end
  end

  assign key_q    = key_r;
  assign handle_q = handle_r;
  assign hit      = occupied && (key_r == key_in);

endmodule
